FILE: sv/rrmt_pkg.sv
// ----------------------------------------------------------------------------
// rrmt_pkg: shared types and constants of the received range merge tracker
// Holds command and status codes, controller states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none
package rrmt_pkg;
    localparam int MAX_INTERVALS_DEF = 16;
    localparam logic [24:0] PIECE_LENGTH_RST = 25'd262144;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_HELD        = 3'd1,
        ST_NOT_STARTED = 3'd2,
        ST_WRONG_ID    = 3'd3,
        ST_COVERS      = 3'd4,
        ST_FULL        = 3'd5,
        ST_PAST_END    = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN, S_RDPREV, S_TRIMP, S_RDNEXT, S_TRIMN,
        S_DECIDE, S_SHIFTL, S_SHIFTR, S_WRITE, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic check;      // run front checks
        logic scan_step;  // compare one entry during search
        logic rd_prev;    // read entry n-1
        logic trim_prev;
        logic rd_next;    // read entry n
        logic trim_next;
        logic decide;     // settle merge kind
        logic shl_step;   // move one entry down
        logic shr_step;   // move one entry up
        logic commit;     // final table write
        logic out_load;   // latch result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic early_done; // result settled by the checks
        logic scan_done;
        logic has_prev;
        logic has_next;
        logic abort;      // trim failed, nothing left or table full
        logic merge_both;
        logic need_ins;
        logic full;
        logic shift_done;
    } t_sts;
endpackage
`default_nettype wire

FILE: sv/rrmt_ctrl.sv
// ----------------------------------------------------------------------------
// rrmt_ctrl: sequencer of the range merge tracker
// Steps one item through check, search, trim, shift and write phases.
// ----------------------------------------------------------------------------
`default_nettype none
module rrmt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire rrmt_pkg::t_sts  i_sts,
    output rrmt_pkg::t_ctl       o_ctl
);
    rrmt_pkg::t_state r_state, n_state;
    logic r_ovalid, n_ovalid;

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrmt_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        o_in_ready = 1'b0;
        n_ovalid = r_ovalid && !i_out_ready;
        case (r_state)
            rrmt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = rrmt_pkg::S_CHECK;
                end
            end
            rrmt_pkg::S_CHECK: begin
                o_ctl.check = 1'b1;
                n_state = i_sts.early_done ? rrmt_pkg::S_DONE : rrmt_pkg::S_SCAN;
            end
            rrmt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.has_prev ? rrmt_pkg::S_RDPREV :
                              i_sts.has_next ? rrmt_pkg::S_RDNEXT : rrmt_pkg::S_DECIDE;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            rrmt_pkg::S_RDPREV: begin
                o_ctl.rd_prev = 1'b1;
                n_state = rrmt_pkg::S_TRIMP;
            end
            rrmt_pkg::S_TRIMP: begin
                o_ctl.trim_prev = 1'b1;
                n_state = i_sts.has_next ? rrmt_pkg::S_RDNEXT : rrmt_pkg::S_DECIDE;
            end
            rrmt_pkg::S_RDNEXT: begin
                if (i_sts.abort) begin
                    n_state = rrmt_pkg::S_DONE;
                end else begin
                    o_ctl.rd_next = 1'b1;
                    n_state = rrmt_pkg::S_TRIMN;
                end
            end
            rrmt_pkg::S_TRIMN: begin
                o_ctl.trim_next = 1'b1;
                n_state = rrmt_pkg::S_DECIDE;
            end
            rrmt_pkg::S_DECIDE: begin
                if (i_sts.abort) begin
                    n_state = rrmt_pkg::S_DONE;
                end else begin
                    o_ctl.decide = 1'b1;
                    n_state = i_sts.merge_both ? rrmt_pkg::S_SHIFTL :
                              !i_sts.need_ins ? rrmt_pkg::S_WRITE :
                              i_sts.full ? rrmt_pkg::S_DONE : rrmt_pkg::S_SHIFTR;
                end
            end
            rrmt_pkg::S_SHIFTL: begin
                if (i_sts.shift_done) n_state = rrmt_pkg::S_WRITE;
                else o_ctl.shl_step = 1'b1;
            end
            rrmt_pkg::S_SHIFTR: begin
                if (i_sts.shift_done) n_state = rrmt_pkg::S_WRITE;
                else o_ctl.shr_step = 1'b1;
            end
            rrmt_pkg::S_WRITE: begin
                o_ctl.commit = 1'b1;
                n_state = rrmt_pkg::S_DONE;
            end
            rrmt_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = rrmt_pkg::S_IDLE;
                end
            end
            default: n_state = rrmt_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/rrmt_dp.sv
// ----------------------------------------------------------------------------
// rrmt_dp: datapath of the range merge tracker
// Holds the interval table in memories, the trimmed range and the result.
// ----------------------------------------------------------------------------
`default_nettype none
module rrmt_dp #(
    parameter int MAX_INTERVALS = rrmt_pkg::MAX_INTERVALS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rrmt_pkg::t_ctl  i_ctl,
    output rrmt_pkg::t_sts       o_sts,
    input  wire logic            i_cfg_we,
    input  wire logic [24:0]     i_cfg_data,
    input  wire logic [1:0]      i_cmd,
    input  wire logic [31:0]     i_piece_id,
    input  wire logic [23:0]     i_range_offset,
    input  wire logic [24:0]     i_range_length,
    output logic [2:0]           o_status,
    output logic [23:0]          o_write_offset,
    output logic [24:0]          o_write_length,
    output logic [24:0]          o_source_skip,
    output logic                 o_piece_complete
);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);

    logic [24:0] r_mem_s [MAX_INTERVALS];
    logic [24:0] r_mem_l [MAX_INTERVALS];

    logic [24:0] r_plen;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_piece;
    logic r_started;
    logic [1:0] r_cmd;
    logic [31:0] r_id;
    logic [23:0] r_off;
    logic [25:0] r_lo, r_hi;
    logic [CW-1:0] r_n, r_ptr;
    logic [2:0] r_st;
    logic r_early, r_abort, r_mp, r_mn;
    logic [24:0] r_ps, r_pl, r_nl;   // start/length of prev, length of next
    logic [25:0] r_ns;
    logic [24:0] r_rd_s, r_rd_l;     // registered memory read
    logic [24:0] r_first_l;          // copy of entry 0 length
    logic r_mb, r_ins;
    logic [2:0] r_ost;
    logic [23:0] r_owo;
    logic [24:0] r_owl, r_osk;
    logic r_ocomp;
    logic r_shv;
    logic [CW-1:0] r_shdst;

    // memory port: one read address, one write address
    logic [AW-1:0] w_raddr, w_waddr;
    logic w_we;
    logic [24:0] w_ws, w_wl;
    logic [25:0] w_pe, w_rs, w_re, w_sum, w_hi_in;
    logic w_mp, w_mn;

    assign w_pe = {1'b0, r_ps} + {1'b0, r_pl};
    assign w_rs = {1'b0, r_rd_s};
    assign w_re = {1'b0, r_rd_s} + {1'b0, r_rd_l};
    assign w_sum = r_hi - r_lo;
    assign w_hi_in = {2'b0, i_range_offset} + {1'b0, i_range_length};
    assign w_mp = (r_n != '0) && (w_pe == r_lo);
    assign w_mn = (r_n < r_cnt) && (r_hi == r_ns);

    // pick read address for the phase
    always_comb begin
        w_raddr = r_ptr[AW-1:0];
        if (i_ctl.scan_step) w_raddr = AW'(r_ptr + 1'b1);
        if (i_ctl.rd_prev) w_raddr = AW'(r_n - 1'b1);
        if (i_ctl.rd_next) w_raddr = r_n[AW-1:0];
        if (i_ctl.shl_step) w_raddr = AW'(r_ptr + 1'b1);
        if (i_ctl.shr_step) w_raddr = AW'(r_ptr - 1'b1);
    end

    // memory reads and writes
    always_ff @(posedge i_clk) begin
        r_rd_s <= r_mem_s[w_raddr];
        r_rd_l <= r_mem_l[w_raddr];
        if (w_we) begin
            r_mem_s[w_waddr] <= w_ws;
            r_mem_l[w_waddr] <= w_wl;
        end
    end

    // shift moves store the word read last cycle; commit writes the merged or new entry
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_shdst[AW-1:0];
        w_ws = r_rd_s;
        w_wl = r_rd_l;
        if (r_shv) w_we = 1'b1;
        if (i_ctl.commit) begin
            w_we = 1'b1;
            if (r_mb || r_mp) begin
                w_waddr = AW'(r_n - 1'b1);
                w_ws = r_ps;
                w_wl = r_mb ? 25'(w_sum + {1'b0, r_pl} + {1'b0, r_nl})
                            : 25'(w_sum + {1'b0, r_pl});
            end else if (r_mn) begin
                w_waddr = r_n[AW-1:0];
                w_ws = r_lo[24:0];
                w_wl = 25'(w_sum + {1'b0, r_nl});
            end else begin
                w_waddr = r_n[AW-1:0];
                w_ws = r_lo[24:0];
                w_wl = w_sum[24:0];
            end
        end
    end

    assign o_sts.early_done = r_early;
    assign o_sts.scan_done = (r_ptr >= r_cnt) || r_abort;
    assign o_sts.has_prev = (r_n != '0);
    assign o_sts.has_next = (r_n < r_cnt);
    assign o_sts.abort = r_abort;
    assign o_sts.merge_both = w_mp && w_mn;
    assign o_sts.need_ins = !w_mp && !w_mn;
    assign o_sts.full = (r_cnt >= MAXC);
    assign o_sts.shift_done = r_mb ? (CW'(r_ptr + 1'b1) >= r_cnt) : (r_ptr <= r_n);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= rrmt_pkg::PIECE_LENGTH_RST;
            r_cnt <= '0;
            r_piece <= '0;
            r_started <= 1'b0;
            r_shv <= 1'b0;
        end else begin
            if (i_cfg_we) r_plen <= i_cfg_data;
            r_shv <= i_ctl.shl_step || i_ctl.shr_step;
            if (i_ctl.check) begin
                if (r_cmd == rrmt_pkg::CMD_START) begin
                    r_cnt <= '0; r_piece <= r_id; r_started <= 1'b1;
                end else if (r_cmd == rrmt_pkg::CMD_RELEASE) begin
                    r_cnt <= '0; r_piece <= '0; r_started <= 1'b0;
                end
            end
            if (i_ctl.commit) begin
                if (r_mb) r_cnt <= r_cnt - 1'b1;
                else if (r_ins) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd; r_id <= i_piece_id; r_off <= i_range_offset;
            r_lo <= {2'b0, i_range_offset}; r_hi <= w_hi_in;
            r_n <= '0; r_ptr <= '0; r_abort <= 1'b0; r_st <= rrmt_pkg::ST_OK;
            r_mp <= 1'b0; r_mn <= 1'b0; r_mb <= 1'b0; r_ins <= 1'b0;
            r_early <= 1'b1;
            if (i_cmd != rrmt_pkg::CMD_ADD) r_early <= 1'b1;
            else if (!r_started) r_st <= rrmt_pkg::ST_NOT_STARTED;
            else if (i_piece_id != r_piece) r_st <= rrmt_pkg::ST_WRONG_ID;
            else if (w_hi_in > {1'b0, r_plen}) r_st <= rrmt_pkg::ST_PAST_END;
            else if (i_range_length == '0) r_st <= rrmt_pkg::ST_OK;
            else r_early <= 1'b0;
        end
        // count entries that start at or before the offset
        if (i_ctl.scan_step) begin
            if (r_rd_s <= {1'b0, r_off} && r_ptr < r_cnt && r_ptr == r_n) begin
                r_n <= r_n + 1'b1;
            end
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_ctl.check) r_ptr <= '0;
        // trim against the entry before the range
        if (i_ctl.trim_prev) begin
            r_ps <= r_rd_s; r_pl <= r_rd_l;
            if (!(r_hi <= w_rs || r_lo >= w_re)) begin
                if (r_lo < w_rs) begin
                    if (w_re < r_hi) begin r_abort <= 1'b1; r_st <= rrmt_pkg::ST_COVERS; end
                    else r_hi <= w_rs;
                end else if (r_hi <= w_re) begin
                    r_abort <= 1'b1; r_st <= rrmt_pkg::ST_HELD;
                end else r_lo <= w_re;
            end
        end
        // trim against the entry after the range
        if (i_ctl.trim_next) begin
            r_ns <= w_rs; r_nl <= r_rd_l;
            if (!r_abort && r_hi > r_lo && !(r_hi <= w_rs || r_lo >= w_re)) begin
                if (r_lo < w_rs) begin
                    if (w_re < r_hi) begin r_abort <= 1'b1; r_st <= rrmt_pkg::ST_COVERS; end
                    else r_hi <= w_rs;
                end else if (r_hi <= w_re) begin
                    r_abort <= 1'b1; r_st <= rrmt_pkg::ST_HELD;
                end else r_lo <= w_re;
            end
        end
        if (i_ctl.decide) begin
            r_mp <= w_mp;
            r_mn <= w_mn;
            r_mb <= w_mp && w_mn;
            r_ins <= !w_mp && !w_mn && (r_cnt < MAXC);
            if (w_mp && w_mn) r_ptr <= r_n;
            else r_ptr <= r_cnt;
            if (!w_mp && !w_mn && r_cnt >= MAXC) begin
                r_abort <= 1'b1; r_st <= rrmt_pkg::ST_FULL;
            end
        end
        if (i_ctl.shl_step) begin
            r_shdst <= r_ptr; r_ptr <= r_ptr + 1'b1;
        end
        if (i_ctl.shr_step) begin
            r_shdst <= r_ptr; r_ptr <= r_ptr - 1'b1;
        end
        if (i_ctl.out_load) begin
            r_ost <= r_st;
            if (r_st == rrmt_pkg::ST_OK && !r_early && !r_abort) begin
                r_owo <= r_lo[23:0];
                r_owl <= 25'(r_hi - r_lo);
                r_osk <= 25'(r_lo - {2'b0, r_off});
            end else begin
                r_owo <= '0; r_owl <= '0; r_osk <= '0;
            end
            r_ocomp <= (r_cnt != '0) && (r_first_l == r_plen);
        end
    end

    // entry 0 length mirror for completion
    always_ff @(posedge i_clk) begin
        if (w_we && w_waddr == '0) r_first_l <= w_wl;
    end

    assign o_status = r_ost;
    assign o_write_offset = r_owo;
    assign o_write_length = r_owl;
    assign o_source_skip = r_osk;
    assign o_piece_complete = r_ocomp;
endmodule
`default_nettype wire

FILE: sv/received_range_merge_tracker_core.sv
// ----------------------------------------------------------------------------
// received_range_merge_tracker_core: received byte range tracker
// Keeps a sorted table of held intervals and merges arriving ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries cmd, piece_id and a range.
//   Output channel o_out_valid/i_out_ready returns one result per item:
//   status, trimmed write region, payload skip and piece completion.
//   piece_length is written through i_cfg_we/i_cfg_data; the user must
//   write it only while idle, the block itself does not enforce this.
//   One item at a time: start, release and rejects pass the checks only;
//   an add also searches the table, trims the range and moves entries
//   through its single read port before the table write.
//   The result register lets the next item enter while a result waits;
//   a stalled receiver only blocks the item after that.
//   Reset empties the table, clears the piece id and sets piece_length
//   to 262144; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module received_range_merge_tracker_core #(
    parameter int MAX_INTERVALS = rrmt_pkg::MAX_INTERVALS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_piece_id,
    input  wire logic [23:0] i_range_offset,
    input  wire logic [24:0] i_range_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [23:0]      o_write_offset,
    output logic [24:0]      o_write_length,
    output logic [24:0]      o_source_skip,
    output logic             o_piece_complete
);
    rrmt_pkg::t_ctl w_ctl;
    rrmt_pkg::t_sts w_sts;

    rrmt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(w_sts), .o_ctl(w_ctl)
    );

    rrmt_dp #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .o_sts(w_sts),
        .i_cfg_we, .i_cfg_data, .i_cmd, .i_piece_id, .i_range_offset,
        .i_range_length, .o_status, .o_write_offset, .o_write_length,
        .o_source_skip, .o_piece_complete
    );
endmodule
`default_nettype wire

FILE: sv/rrmt_chk.sv
// ----------------------------------------------------------------------------
// rrmt_chk: port checker of the range merge tracker
// Watches handshakes and result fields on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module rrmt_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [24:0] o_write_length,
    input wire logic [24:0] o_source_skip
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");
    // rejected items carry no write region
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rrmt_pkg::ST_OK |->
            o_write_length == '0 && o_source_skip == '0)
        else $error("write region on rejected item");
    // status stays in its code range
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= rrmt_pkg::ST_PAST_END)
        else $error("bad status code");
    // no output after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("valid after reset");
endmodule

bind received_range_merge_tracker_core rrmt_chk u_chk (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_ready,
    .o_status, .o_write_length, .o_source_skip
);
`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of received_range_merge_tracker_core
// Drives start/add/release/nop items with random idling on both channels, keeps
// an interval table of its own to predict each result and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NINT = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [24:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_piece_id = '0;
    logic [23:0] i_range_offset = '0;
    logic [24:0] i_range_length = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [23:0] o_write_offset;
    logic [24:0] o_write_length;
    logic [24:0] o_source_skip;
    logic        o_piece_complete;

    received_range_merge_tracker_core #(.MAX_INTERVALS(NINT)) dut (.*);

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] wr_off;
        logic [24:0] wr_len;
        logic [24:0] skip;
        logic        complete;
    } t_result;

    // tracker copy
    logic [24:0] pc_len;
    logic [24:0] iv_start [NINT];
    logic [24:0] iv_len [NINT];
    int          iv_cnt;
    logic [31:0] cur_id;
    logic        started;

    t_result     pending_results[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // trim [lo,hi) against held [rs,re): 0 kept, 1 inside, 2 covers
    function automatic int trim_range(inout longint lo, inout longint hi,
                                      input longint rs, input longint re);
        if (hi <= rs || lo >= re) return 0;
        if (lo < rs) begin
            if (re < hi) return 2;
            hi = rs;
            return 0;
        end
        if (hi < re) return 1;
        lo = re;
        return 0;
    endfunction

    function automatic t_result settle(input rrmt_pkg::t_status st, input longint lo,
                                       input longint wl, input longint sk);
        t_result r;
        r.status   = st;
        r.wr_off   = lo[23:0];
        r.wr_len   = wl[24:0];
        r.skip     = sk[24:0];
        r.complete = (iv_cnt > 0 && iv_len[0] == pc_len);
        return r;
    endfunction

    function automatic t_result track_add(input logic [31:0] id, input longint off,
                                          input longint len);
        longint lo, hi, ps, ns;
        int n, r;
        bit mp, mn;
        lo = off;
        hi = off + len;
        n = 0;
        if (!started) return settle(rrmt_pkg::ST_NOT_STARTED, 0, 0, 0);
        if (id != cur_id) return settle(rrmt_pkg::ST_WRONG_ID, 0, 0, 0);
        if (hi > longint'(pc_len)) return settle(rrmt_pkg::ST_PAST_END, 0, 0, 0);
        if (len == 0) return settle(rrmt_pkg::ST_OK, 0, 0, 0);
        while (n < iv_cnt && longint'(iv_start[n]) <= off) n++;
        if (n > 0) begin
            ps = iv_start[n-1];
            r = trim_range(lo, hi, ps, ps + iv_len[n-1]);
            if (r == 1) return settle(rrmt_pkg::ST_HELD, 0, 0, 0);
            if (r == 2) return settle(rrmt_pkg::ST_COVERS, 0, 0, 0);
        end
        if (n < iv_cnt && hi > lo) begin
            ns = iv_start[n];
            r = trim_range(lo, hi, ns, ns + iv_len[n]);
            if (r == 1) return settle(rrmt_pkg::ST_HELD, 0, 0, 0);
            if (r == 2) return settle(rrmt_pkg::ST_COVERS, 0, 0, 0);
        end
        if (hi <= lo) return settle(rrmt_pkg::ST_HELD, 0, 0, 0);
        mp = n > 0 && longint'(iv_start[n-1]) + iv_len[n-1] == lo;
        mn = n < iv_cnt && hi == longint'(iv_start[n]);
        if (mp && mn) begin
            iv_len[n-1] = iv_len[n-1] + 25'(hi - lo) + iv_len[n];
            for (int i = n; i + 1 < iv_cnt; i++) begin
                iv_start[i] = iv_start[i+1];
                iv_len[i] = iv_len[i+1];
            end
            iv_cnt--;
        end else if (mp) begin
            iv_len[n-1] = iv_len[n-1] + 25'(hi - lo);
        end else if (mn) begin
            iv_start[n] = 25'(lo);
            iv_len[n] = iv_len[n] + 25'(hi - lo);
        end else begin
            if (iv_cnt >= NINT) return settle(rrmt_pkg::ST_FULL, 0, 0, 0);
            for (int i = iv_cnt; i > n; i--) begin
                iv_start[i] = iv_start[i-1];
                iv_len[i] = iv_len[i-1];
            end
            iv_start[n] = 25'(lo);
            iv_len[n] = 25'(hi - lo);
            iv_cnt++;
        end
        return settle(rrmt_pkg::ST_OK, lo, hi - lo, lo - off);
    endfunction

    function automatic t_result track_item(input rrmt_pkg::t_cmd c, input logic [31:0] id,
                                           input logic [23:0] off, input logic [24:0] len);
        case (c)
            rrmt_pkg::CMD_START: begin
                iv_cnt = 0;
                cur_id = id;
                started = 1'b1;
            end
            rrmt_pkg::CMD_ADD: return track_add(id, off, len);
            rrmt_pkg::CMD_RELEASE: begin
                iv_cnt = 0;
                cur_id = '0;
                started = 1'b0;
            end
            default: ;
        endcase
        return settle(rrmt_pkg::ST_OK, 0, 0, 0);
    endfunction

    // send one item; valid held until accepted, dropped only while idling
    task automatic send_item(input rrmt_pkg::t_cmd c, input logic [31:0] id,
                             input logic [23:0] off, input logic [24:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= c;
        i_piece_id     <= id;
        i_range_offset <= off;
        i_range_length <= len;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(track_item(c, id, off, len));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_piece_length(input logic [24:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pc_len = v;
    endtask

    // receiver side
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_status, -1);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status != exp_r.status) report("status", o_status, exp_r.status);
                if (o_write_offset != exp_r.wr_off)
                    report("write_offset", o_write_offset, exp_r.wr_off);
                if (o_write_length != exp_r.wr_len)
                    report("write_length", o_write_length, exp_r.wr_len);
                if (o_source_skip != exp_r.skip)
                    report("source_skip", o_source_skip, exp_r.skip);
                if (o_piece_complete != exp_r.complete)
                    report("piece_complete", o_piece_complete, exp_r.complete);
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[received_range_merge_tracker_core] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        write_piece_length(25'd64);
        send_item(rrmt_pkg::CMD_ADD, 32'd5, 24'd0, 25'd4);          // not started
        send_item(rrmt_pkg::CMD_START, 32'hFFFF_FFFF, 24'd0, 25'd0);
        send_item(rrmt_pkg::CMD_ADD, 32'd0, 24'd0, 25'd4);          // wrong id
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd60, 25'd5); // past end
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd3, 25'd0);  // zero length
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd10, 25'd10);
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd12, 25'd8); // held, same end
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd12, 25'd3); // inside
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd5, 25'd20); // covers
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd15, 25'd10);// trim front, merge
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd30, 25'd4);
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd25, 25'd5); // join both
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd0, 25'd12); // trim back
        send_item(rrmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 24'd34, 25'd30);// complete
        send_item(rrmt_pkg::CMD_NOP, 32'h1234_5678, 24'hFF_FFFF, 25'h1FF_FFFF);
        send_item(rrmt_pkg::CMD_RELEASE, 32'd9, 24'd0, 25'd0);
        // table full
        send_item(rrmt_pkg::CMD_START, 32'd7, 24'd0, 25'd0);
        for (int k = 0; k < 17; k++)
            send_item(rrmt_pkg::CMD_ADD, 32'd7, 24'(2 * k), 25'd1);
        write_piece_length(25'h100_0000);
        send_item(rrmt_pkg::CMD_START, 32'd1, 24'd0, 25'd0);
        send_item(rrmt_pkg::CMD_ADD, 32'd1, 24'hFF_FFFF, 25'd1);
        send_item(rrmt_pkg::CMD_ADD, 32'd1, 24'd0, 25'h100_0000);   // trim back, merge, complete
        send_item(rrmt_pkg::CMD_ADD, 32'd1, 24'd0, 25'hFF_FFFF);    // held, complete
        write_piece_length(25'h1FF_FFFF);                           // oversize register
        send_item(rrmt_pkg::CMD_ADD, 32'd1, 24'hFF_FFFF, 25'h100_0000);
        write_piece_length(25'd1);
        send_item(rrmt_pkg::CMD_START, 32'd2, 24'd0, 25'd0);
        send_item(rrmt_pkg::CMD_ADD, 32'd2, 24'd0, 25'd1);
    endtask

    task automatic random_items(input int count, input int plen);
        logic [31:0] id;
        int off, len;
        write_piece_length(25'(plen));
        id = $urandom;
        send_item(rrmt_pkg::CMD_START, id, 24'($urandom), 25'($urandom));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(99)) inside
                [0:1]:   send_item(rrmt_pkg::CMD_RELEASE, $urandom, 24'($urandom),
                                   25'($urandom));
                [2:4]: begin
                    id = $urandom;
                    send_item(rrmt_pkg::CMD_START, id, 24'($urandom), 25'($urandom));
                end
                [5:6]:   send_item(rrmt_pkg::CMD_NOP, $urandom, 24'($urandom),
                                   25'($urandom));
                [7:9]:   send_item(rrmt_pkg::CMD_ADD, $urandom, 24'($urandom),
                                   25'($urandom));
                default: begin
                    off = $urandom_range(plen - 1);
                    len = $urandom_range(1, (plen > 40) ? plen / 8 : plen);
                    if ($urandom_range(9) == 0) len = $urandom_range(plen);
                    send_item(rrmt_pkg::CMD_ADD, started ? cur_id : id, 24'(off), 25'(len));
                end
            endcase
        end
    endtask

    task automatic test_fill_stall();
        fork
            begin
                // hold off once the piece length is set and items start flowing
                @(posedge i_clk iff i_cfg_we);
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_items(20, 200);
        join
    endtask

    initial begin
        pc_len = rrmt_pkg::PIECE_LENGTH_RST;
        iv_cnt = 0;
        cur_id = '0;
        started = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 13;
        recv_idle_pct = 82;
        test_directed();
        random_items(600, 120);
        send_idle_pct = 82;
        recv_idle_pct = 13;
        random_items(600, 5000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_fill_stall();
        random_items(500, 300);
        random_items(300, 24'hFF_FFFF + 1);
        drain();
        if (errors == 0) begin
            $display("[received_range_merge_tracker_core] OK");
        end else begin
            $display("[received_range_merge_tracker_core] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
